>>> hw/rtl/ierh_pkg.sv
// ----------------------------------------------------------------------------
// ierh_pkg
// Shared types and constants for the interval end reorder heap.
// ----------------------------------------------------------------------------
package ierh_pkg;

    localparam int DEPTH_DEF = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_FLUSH  = 1'b1
    } t_op;

    typedef struct packed {
        logic        op;
        logic [15:0] chrom_id;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic        strand;
        logic [31:0] tag;
    } t_in;

    typedef struct packed {
        logic [15:0] out_chrom;
        logic [31:0] out_start;
        logic [31:0] out_end;
        logic        out_strand;
        logic [31:0] out_tag;
        logic        forced;
        logic        last;
    } t_out;

    // one held record; ordering key is end, strand, start, tag
    typedef struct packed {
        logic [31:0] end_pos;
        logic        strand;
        logic [31:0] start_pos;
        logic [31:0] tag;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_STORE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic scan_init; // begin a minimum search
        logic scan_step; // compare one entry
        logic emit;      // take the minimum as the next beat
        logic emit_force;
        logic move;      // write last entry into the hole, count down
        logic store;     // append the new record
        logic fin;       // item done: release the waiting beat as last
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic scan_done;
        logic drain;      // minimum leaves before the insert
        logic is_flush;
    } t_stat;

endpackage

>>> hw/rtl/ierh_ctrl.sv
// ----------------------------------------------------------------------------
// ierh_ctrl
// Sequencer: repeated minimum search, emit, remove, then insert or end a flush.
// ----------------------------------------------------------------------------
module ierh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output ierh_pkg::t_cmd  o_cmd,
    input  ierh_pkg::t_stat i_stat
);
    import ierh_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // entry check before each search
                if (i_stat.empty) begin
                    if (i_stat.is_flush) begin
                        o_cmd.fin = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_STORE;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (i_stat.is_flush || i_stat.drain) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.move = 1'b1;
                    n_state    = S_DECIDE;
                end else if (i_stat.full) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_force = 1'b1;
                    o_cmd.move       = 1'b1;
                    n_state          = S_STORE;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.fin   = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy);
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_stat.empty);
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> (r_state == S_IDLE));

endmodule

>>> hw/rtl/ierh_dp.sv
// ----------------------------------------------------------------------------
// ierh_dp
// Record store, serial minimum search and result register.
// ----------------------------------------------------------------------------
module ierh_dp #(
    parameter int DEPTH = ierh_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ierh_pkg::t_in   i_item,
    input  ierh_pkg::t_cmd  i_cmd,
    output ierh_pkg::t_stat o_stat,
    output logic            o_valid,
    output ierh_pkg::t_out  o_result
);
    import ierh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    t_in           r_item;
    logic [CW-1:0] r_count;
    logic [15:0]   r_chrom;
    logic          r_other;

    logic [CW-1:0] r_scan;
    logic [AW-1:0] r_best_idx;
    t_rec          r_rd, r_best;
    logic          r_pend;   // beat waits until it is known whether it is the last
    t_out          r_res;
    logic          r_valid;
    t_out          r_out;

    logic [AW-1:0] w_last_idx;
    logic [AW-1:0] w_rd_addr;
    logic          w_release;
    t_out          w_out;

    function automatic logic rec_lt(t_rec a, t_rec b);
        return {a.end_pos, a.strand, a.start_pos, a.tag}
             < {b.end_pos, b.strand, b.start_pos, b.tag};
    endfunction

    assign w_last_idx = AW'(r_count - CW'(1));

    // search walks 0..count-1; the final step fetches the last entry for the move
    always_comb begin
        if (i_cmd.scan_step && (r_scan < r_count)) begin
            w_rd_addr = AW'(r_scan);
        end else if (i_cmd.scan_step) begin
            w_rd_addr = w_last_idx;
        end else begin
            w_rd_addr = '0;
        end
    end

    // memory: one registered read, one write
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[AW'(r_count)] <= '{r_item.end_pos, r_item.strand,
                                    r_item.start_pos, r_item.tag};
        end else if (i_cmd.move && (r_best_idx != w_last_idx)) begin
            r_mem[r_best_idx] <= r_rd;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.scan_init) begin
            r_scan <= CW'(1);
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + CW'(1);
        end
    end

    // during each step r_rd holds entry r_scan-1
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && ((r_scan == CW'(1)) || rec_lt(r_rd, r_best))) begin
            r_best     <= r_rd;
            r_best_idx <= AW'(r_scan - CW'(1));
        end
    end

    // final compare happens in the step where r_scan reaches count
    assign o_stat.scan_done = (r_scan == r_count);

    assign w_release = r_pend && (i_cmd.emit || i_cmd.fin);

    always_comb begin
        w_out      = r_res;
        w_out.last = i_cmd.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_chrom <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= w_release;
            if (w_release) begin
                r_out <= w_out;
            end
            if (i_cmd.load) begin
                r_item  <= i_item;
                r_other <= (i_item.chrom_id != r_chrom);
            end
            if (i_cmd.emit) begin
                r_res  <= '{r_chrom, r_best.start_pos, r_best.end_pos,
                           r_best.strand, r_best.tag, i_cmd.emit_force, 1'b0};
                r_pend <= 1'b1;
            end else if (i_cmd.fin) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.move) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.store) begin
                r_count <= r_count + CW'(1);
                r_chrom <= r_item.chrom_id;
            end
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.is_flush = (r_item.op == OP_FLUSH);
    assign o_stat.drain    = r_other || (r_best.end_pos < r_item.start_pos);

    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH));
    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_count < CW'(DEPTH)));
    a_move_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |-> (r_count != '0));

endmodule

>>> hw/rtl/interval_end_reorder_heap_top.sv
// ----------------------------------------------------------------------------
// interval_end_reorder_heap_top
// Re-sorts start-ordered intervals into end order.
// ----------------------------------------------------------------------------
// Each emitted interval costs one serial minimum search over the held
// records, serial because the record store has a single read port. An insert
// that stops draining on a non-empty store without a forced emit pays one
// more search. Results are single-cycle o_valid beats which the receiver
// cannot stall; o_result.last marks the final beat of an item. Each beat is
// held back until the next interval is picked or the item finishes, so the
// final beat of an item comes out in the same cycle that busy falls.
// ----------------------------------------------------------------------------
module interval_end_reorder_heap_top #(
    parameter int DEPTH = ierh_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ierh_pkg::t_in  i_item,
    output logic           o_valid,
    output ierh_pkg::t_out o_result
);
    import ierh_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ierh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    ierh_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
